/* hw/rtl/arcbb_pkg.sv */
package arcbb_pkg;

   localparam int CORDIC_STAGES_DEF = 24;
   localparam int ATAN_COUNT        = 30;

   // CORDIC datapath widths: Q30 with headroom for gain growth
   localparam int XW = 34;
   localparam int ZW = 32;
   // points before saturation
   localparam int PW = 36;

   localparam logic signed [XW-1:0] GAIN_Q30 = XW'(34'sh026DD3B6A);

   // angle reduction constants, 1/256 degree units
   localparam int TURN_UNITS      = 92160;
   localparam int QUARTER_UNITS   = 23040;
   localparam int WRAP_OFFSET     = 63488;  // 2^31 mod one turn
   localparam int DIV45_HI_MULT   = 2982617; // ceil(2^27 / 45)
   localparam int DIV45_LO_MULT   = 93207;   // ceil(2^22 / 45)

   typedef logic [31:0] atan_table_type [ATAN_COUNT];
   localparam atan_table_type ATAN_TURN = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // low 21 bits of the binary angle for each residue of r mod 45
   typedef logic [20:0] frac_table_type [45];

   function automatic frac_table_type build_frac();
      frac_table_type t;
      for (int c = 0; c < 45; c++) begin
         t[c] = 21'((c * 2097152 + 22) / 45);
      end
      return t;
   endfunction

   localparam frac_table_type FRAC_TABLE = build_frac();

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [1:0]           quad;
   } cordic_type;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [30:0]        rad;
   } geo_type;

   typedef struct packed {
      geo_type    geo;
      logic [3:0] card;  // 0, 90, 180, 270 degrees inside the span
   } side_type;

   function automatic logic signed [31:0] sat32(logic signed [PW-1:0] v);
      logic signed [PW-1:0] hi;
      logic signed [PW-1:0] lo;
      hi = PW'(32'sh7FFFFFFF);
      lo = PW'(-33'sh080000000);
      if (v > hi) return 32'sh7FFFFFFF;
      if (v < lo) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

/* hw/rtl/arc_bounding_box.sv */
// Throughput: one request per cycle; the angle reducers, the CORDIC cell rows
// and the scale/box stages are all fully pipelined.
// A stalled response holds the whole pipeline.
// Reset clears only the stage valid bits; no clearing pass.
module arc_bounding_box
   import arcbb_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic [30:0]        req_radius,
   input  logic signed [31:0] req_start_angle,
   input  logic signed [31:0] req_end_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_min_x,
   output logic signed [31:0] rsp_min_y,
   output logic signed [31:0] rsp_max_x,
   output logic signed [31:0] rsp_max_y
);

   localparam int REDUCE_DEPTH = 4;
   localparam int LATENCY      = REDUCE_DEPTH + CORDIC_STAGES + 3;

   logic en;
   logic [LATENCY-1:0] vld_in, vld_ff;

   assign en        = !(vld_ff[LATENCY-1] && rsp_stall);
   assign req_stall = !en || reset;

   assign vld_in = {vld_ff[LATENCY-2:0], req_valid && en};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // angle reduction
   logic [16:0] rs, re;
   logic [31:0] bs, be;

   arcbb_angle_reduce u_red_start (
      .clock(clock), .en(en), .angle(req_start_angle),
      .red_angle(rs), .bin_angle(bs)
   );
   arcbb_angle_reduce u_red_end (
      .clock(clock), .en(en), .angle(req_end_angle),
      .red_angle(re), .bin_angle(be)
   );

   geo_type geo_ff [REDUCE_DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         geo_ff[0] <= '{cx: req_center_x, cy: req_center_y, rad: req_radius};
         for (int i = 1; i < REDUCE_DEPTH; i++) begin
            geo_ff[i] <= geo_ff[i-1];
         end
      end
   end

   function automatic logic in_span(logic [16:0] s, logic [16:0] e, logic [16:0] d);
      if (s <= e) return (s <= d) && (d < e);
      return (s <= d) || (d < e);
   endfunction

   side_type side_in;
   always_comb begin
      side_in.geo     = geo_ff[REDUCE_DEPTH-1];
      side_in.card[0] = in_span(rs, re, 17'd0);
      side_in.card[1] = in_span(rs, re, 17'(QUARTER_UNITS));
      side_in.card[2] = in_span(rs, re, 17'(2 * QUARTER_UNITS));
      side_in.card[3] = in_span(rs, re, 17'(3 * QUARTER_UNITS));
   end

   // CORDIC rows
   cordic_type cs_chain [CORDIC_STAGES+1];
   cordic_type ce_chain [CORDIC_STAGES+1];
   side_type   side_ff  [CORDIC_STAGES];

   assign cs_chain[0] = '{x: GAIN_Q30, y: '0, z: ZW'({2'b00, bs[29:0]}), quad: bs[31:30]};
   assign ce_chain[0] = '{x: GAIN_Q30, y: '0, z: ZW'({2'b00, be[29:0]}), quad: be[31:30]};

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_row
      arcbb_cordic_cell #(.STAGE(g)) u_cs (
         .clock(clock), .en(en), .cin(cs_chain[g]), .cout(cs_chain[g+1])
      );
      arcbb_cordic_cell #(.STAGE(g)) u_ce (
         .clock(clock), .en(en), .cin(ce_chain[g]), .cout(ce_chain[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < CORDIC_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // quadrant fold and scale by radius
   function automatic logic signed [2*XW-1:0] rot_pair(cordic_type v);
      logic signed [XW-1:0] c;
      logic signed [XW-1:0] s;
      unique case (v.quad)
         2'd0: begin c = v.x;  s = v.y;  end
         2'd1: begin c = -v.y; s = v.x;  end
         2'd2: begin c = -v.x; s = -v.y; end
         default: begin c = v.y;  s = -v.x; end
      endcase
      return {c, s};
   endfunction

   logic signed [XW-1:0] c0, s0, c1, s1;
   logic signed [32:0]   rad_s;
   logic signed [63:0]   psx_in, psy_in, pex_in, pey_in;
   logic signed [63:0]   psx_ff, psy_ff, pex_ff, pey_ff;
   side_type             mside_ff, pside_ff;

   always_comb begin
      {c0, s0} = rot_pair(cs_chain[CORDIC_STAGES]);
      {c1, s1} = rot_pair(ce_chain[CORDIC_STAGES]);
      rad_s    = $signed({2'b00, side_ff[CORDIC_STAGES-1].geo.rad});
      psx_in   = 64'(rad_s) * 64'(c0);
      psy_in   = 64'(rad_s) * 64'(s0);
      pex_in   = 64'(rad_s) * 64'(c1);
      pey_in   = 64'(rad_s) * 64'(s1);
   end

   // endpoints
   localparam logic signed [63:0] HALF = 64'sd536870912;
   logic signed [63:0] osx, osy, oex, oey;
   logic signed [PW-1:0] sx_in, sy_in, ex_in, ey_in;
   logic signed [PW-1:0] sx_ff, sy_ff, ex_ff, ey_ff;

   always_comb begin
      osx   = (psx_ff + HALF) >>> 30;
      osy   = (psy_ff + HALF) >>> 30;
      oex   = (pex_ff + HALF) >>> 30;
      oey   = (pey_ff + HALF) >>> 30;
      sx_in = PW'(mside_ff.geo.cx) + PW'(osx);
      sy_in = PW'(mside_ff.geo.cy) + PW'(osy);
      ex_in = PW'(mside_ff.geo.cx) + PW'(oex);
      ey_in = PW'(mside_ff.geo.cy) + PW'(oey);
   end

   // box
   logic signed [PW-1:0] lox, loy, hix, hiy, rad_w;
   logic signed [31:0]   minx_in, miny_in, maxx_in, maxy_in;
   logic signed [31:0]   minx_ff, miny_ff, maxx_ff, maxy_ff;

   always_comb begin
      rad_w = $signed(PW'({1'b0, pside_ff.geo.rad}));
      lox   = (sx_ff < ex_ff) ? sx_ff : ex_ff;
      loy   = (sy_ff < ey_ff) ? sy_ff : ey_ff;
      hix   = (sx_ff > ex_ff) ? sx_ff : ex_ff;
      hiy   = (sy_ff > ey_ff) ? sy_ff : ey_ff;
      if (pside_ff.card[0]) hix = PW'(pside_ff.geo.cx) + rad_w;
      if (pside_ff.card[1]) hiy = PW'(pside_ff.geo.cy) + rad_w;
      if (pside_ff.card[2]) lox = PW'(pside_ff.geo.cx) - rad_w;
      if (pside_ff.card[3]) loy = PW'(pside_ff.geo.cy) - rad_w;
      minx_in = sat32(lox);
      miny_in = sat32(loy);
      maxx_in = sat32(hix);
      maxy_in = sat32(hiy);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         psx_ff   <= psx_in;
         psy_ff   <= psy_in;
         pex_ff   <= pex_in;
         pey_ff   <= pey_in;
         mside_ff <= side_ff[CORDIC_STAGES-1];
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         ex_ff    <= ex_in;
         ey_ff    <= ey_in;
         pside_ff <= mside_ff;
         minx_ff  <= minx_in;
         miny_ff  <= miny_in;
         maxx_ff  <= maxx_in;
         maxy_ff  <= maxy_in;
      end
   end

   assign rsp_valid = vld_ff[LATENCY-1];
   assign rsp_min_x = minx_ff;
   assign rsp_min_y = miny_ff;
   assign rsp_max_x = maxx_ff;
   assign rsp_max_y = maxy_ff;

endmodule

/* hw/rtl/arcbb_angle_reduce.sv */
module arcbb_angle_reduce
   import arcbb_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] angle,
   output logic [16:0] red_angle,
   output logic [31:0] bin_angle
);

   // stage A: split off the 2^11 factor of a turn, reciprocal multiply by 1/45
   logic [20:0] v_in, v_ff;
   logic [10:0] low_in, low_ff;
   logic [42:0] p1_in, p1_ff;
   // stage B: reduced angle
   logic [15:0] qv;
   logic [20:0] remw;
   logic [16:0] m;
   logic [16:0] r_in, r_ff;
   // stage C
   logic [33:0] p2_in, p2_ff;
   logic [16:0] rc_ff;
   // stage D
   logic [11:0] a;
   logic [16:0] cw;
   logic [5:0]  c;
   logic [31:0] b_in, b_ff;
   logic [16:0] rd_ff;

   always_comb begin
      // offset by 2^31 so the value is unsigned
      v_in   = angle[31:11] ^ 21'h100000;
      low_in = angle[10:0];
      p1_in  = 43'(v_in) * 43'(DIV45_HI_MULT);
   end

   always_comb begin
      qv   = p1_ff[42:27];
      remw = v_ff - 21'(qv) * 21'd45;
      m    = {remw[5:0], low_ff};
      if (m >= 17'(WRAP_OFFSET)) begin
         r_in = m - 17'(WRAP_OFFSET);
      end else begin
         r_in = m + 17'(TURN_UNITS - WRAP_OFFSET);
      end
   end

   assign p2_in = 34'(r_ff) * 34'(DIV45_LO_MULT);

   always_comb begin
      a    = p2_ff[33:22];
      cw   = rc_ff - 17'(a) * 17'd45;
      c    = cw[5:0];
      b_in = {a[10:0], FRAC_TABLE[c]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff   <= v_in;
         low_ff <= low_in;
         p1_ff  <= p1_in;
         r_ff   <= r_in;
         p2_ff  <= p2_in;
         rc_ff  <= r_ff;
         b_ff   <= b_in;
         rd_ff  <= rc_ff;
      end
   end

   assign red_angle = rd_ff;
   assign bin_angle = b_ff;

endmodule

/* hw/rtl/arcbb_cordic_cell.sv */
module arcbb_cordic_cell
   import arcbb_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       en,
   input  cordic_type cin,
   output cordic_type cout
);

   cordic_type cell_in, cell_ff;
   logic signed [XW-1:0] dx;
   logic signed [XW-1:0] dy;
   logic signed [ZW-1:0] atan;

   always_comb begin
      dx   = cin.y >>> STAGE;
      dy   = cin.x >>> STAGE;
      atan = $signed(ATAN_TURN[STAGE]);
      cell_in.quad = cin.quad;
      if (!cin.z[ZW-1]) begin
         cell_in.x = cin.x - dx;
         cell_in.y = cin.y + dy;
         cell_in.z = cin.z - atan;
      end else begin
         cell_in.x = cin.x + dx;
         cell_in.y = cin.y - dy;
         cell_in.z = cin.z + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cout = cell_ff;

endmodule

/* verif/arc_bounding_box_tb.sv */
`timescale 1ns / 100ps

module arc_bounding_box_tb;
   import arcbb_pkg::*;

   localparam int STAGES     = CORDIC_STAGES_DEF;
   localparam int LATENCY    = STAGES + 7;
   localparam int N_RANDOM   = 1000;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [30:0]        rad;
      logic signed [31:0] sa;
      logic signed [31:0] ea;
   } arc_type;

   typedef struct {
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] max_x;
      logic signed [31:0] max_y;
   } box_type;

   // bounding box prediction
   function automatic longint wrap_angle(logic signed [31:0] a);
      longint m;
      m = longint'(a) % TURN_UNITS;
      if (m < 0) m += TURN_UNITS;
      return m;
   endfunction

   function automatic void arc_trig(longint r, output longint c, output longint s);
      logic [63:0] b;
      logic [1:0]  q;
      longint      x, y, z, dx, dy;
      b = ((64'(r) << 32) + 64'(TURN_UNITS / 2)) / 64'(TURN_UNITS);
      q = b[31:30];
      z = longint'(b[29:0]);
      x = longint'(GAIN_Q30);
      y = 0;
      for (int i = 0; i < STAGES && i < ATAN_COUNT; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
         end
      end
      case (q)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint rad_scale(longint rad, longint t);
      return (rad * t + (longint'(1) << 29)) >>> 30;
   endfunction

   function automatic bit spans(longint s, longint e, longint d);
      if (s <= e) return s <= d && d < e;
      return s <= d || d < e;
   endfunction

   function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -64'sh80000000) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic box_type arc_box(arc_type a);
      longint cx, cy, rad, s, e, c0, s0, c1, s1, sx, sy, ex, ey, lox, loy, hix, hiy;
      box_type b;
      cx = a.cx; cy = a.cy; rad = longint'({1'b0, a.rad});
      s = wrap_angle(a.sa);
      e = wrap_angle(a.ea);
      arc_trig(s, c0, s0);
      arc_trig(e, c1, s1);
      sx = cx + rad_scale(rad, c0); sy = cy + rad_scale(rad, s0);
      ex = cx + rad_scale(rad, c1); ey = cy + rad_scale(rad, s1);
      lox = sx < ex ? sx : ex; loy = sy < ey ? sy : ey;
      hix = sx > ex ? sx : ex; hiy = sy > ey ? sy : ey;
      if (spans(s, e, 0)) hix = cx + rad;
      if (spans(s, e, QUARTER_UNITS)) hiy = cy + rad;
      if (spans(s, e, 2 * QUARTER_UNITS)) lox = cx - rad;
      if (spans(s, e, 3 * QUARTER_UNITS)) loy = cy - rad;
      b.min_x = clip32(lox); b.min_y = clip32(loy);
      b.max_x = clip32(hix); b.max_y = clip32(hiy);
      return b;
   endfunction

   class box_scoreboard;
      box_type pending[$];
      int      mismatches;
      int      checked;

      function void note_request(arc_type a);
         pending.push_back(arc_box(a));
      endfunction

      function void check_box(box_type got);
         box_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response %0d %0d %0d %0d",
                        got.min_x, got.min_y, got.max_x, got.max_y);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.min_x !== want.min_x || got.min_y !== want.min_y ||
             got.max_x !== want.max_x || got.max_y !== want.max_y) begin
            mismatches++;
            if (mismatches <= 10)
               $display("box mismatch #%0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                        checked, want.min_x, want.min_y, want.max_x, want.max_y,
                        got.min_x, got.min_y, got.max_x, got.max_y);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_center_x = '0;
   logic signed [31:0] req_center_y = '0;
   logic [30:0]        req_radius = '0;
   logic signed [31:0] req_start_angle = '0;
   logic signed [31:0] req_end_angle = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_min_x, rsp_min_y, rsp_max_x, rsp_max_y;

   arc_bounding_box i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   box_scoreboard board = new();
   int  cycles;
   bit  calm;        // no idling on either side
   bit  hold_off;    // receiver long hold-off
   int  sent;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("arc_bounding_box_tb NOT OK");
         $finish;
      end
   end

   // response side: check, random stall and the long hold-off
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_box('{rsp_min_x, rsp_min_y, rsp_max_x, rsp_max_y});
         rsp_stall <= hold_off || (!calm && $urandom_range(99) < 12);
      end
   end

   initial begin
      int n;
      hold_off = 1'b0;
      wait (sent == 300);
      hold_off = 1'b1;
      n = 0;
      while (n < 200) begin
         @(posedge clock);
         n++;
      end
      hold_off = 1'b0;
   end

   function automatic logic signed [31:0] rand_angle();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($urandom_range(3)) * QUARTER_UNITS + $urandom_range(2) - 1;
         2: return $signed(32'($urandom_range(8)) * QUARTER_UNITS)
                   - $signed(32'(4 * QUARTER_UNITS));
         default: return $signed(32'($urandom_range(2 * TURN_UNITS))) - TURN_UNITS;
      endcase
   endfunction

   function automatic arc_type rand_arc();
      arc_type a;
      a.cx = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(65535) << 12) - (1 << 27);
      a.cy = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(65535) << 12) - (1 << 27);
      a.rad = $urandom_range(3) == 0 ? 31'($urandom()) : 31'($urandom_range(1 << 26));
      a.sa = rand_angle();
      a.ea = $urandom_range(9) == 0 ? a.sa + TURN_UNITS * $signed(32'($urandom_range(2)) - 1)
                                     : rand_angle();
      return a;
   endfunction

   task automatic send_arc(arc_type a);
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_center_x    <= a.cx;
      req_center_y    <= a.cy;
      req_radius      <= a.rad;
      req_start_angle <= a.sa;
      req_end_angle   <= a.ea;
      do @(posedge clock); while (req_stall);
      board.note_request(a);
      sent++;
   endtask

   initial begin
      arc_type directed[$];
      int waited;
      calm = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // extremes, equal angles, wrapped spans, saturation
      directed.push_back('{0, 0, 0, 0, 0});
      directed.push_back('{0, 0, 31'h7FFFFFFF, 0, 0});
      directed.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 0, 100});
      directed.push_back('{32'sh80000000, 32'sh80000000, 31'h7FFFFFFF, 100, 0});
      directed.push_back('{0, 0, 31'h10000, 0, TURN_UNITS});
      directed.push_back('{0, 0, 31'h10000, 32'sh80000000, 32'sh7FFFFFFF});
      directed.push_back('{0, 0, 31'h10000, 32'sh7FFFFFFF, 32'sh80000000});
      directed.push_back('{100, -100, 31'h10000, 3 * QUARTER_UNITS, QUARTER_UNITS});
      directed.push_back('{0, 0, 31'h10000, QUARTER_UNITS, 2 * QUARTER_UNITS});
      directed.push_back('{0, 0, 31'h10000, -QUARTER_UNITS, -1});
      directed.push_back('{0, 0, 31'h10000, -TURN_UNITS, TURN_UNITS});
      directed.push_back('{32'sh7FFF0000, 32'sh80010000, 31'h40000000, 1000, 80000});
      directed.push_back('{-5, 5, 31'h55555555, 2 * QUARTER_UNITS - 1, 2 * QUARTER_UNITS});
      directed.push_back('{32'shAAAAAAAA, 32'sh55555555, 31'h2AAAAAAA, 32'shAAAAAAAA, 32'sh55555555});
      foreach (directed[i]) send_arc(directed[i]);
      for (int i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 600 && i < 750);
         send_arc(rand_arc());
      end
      req_valid <= 1'b0;
      waited = 0;
      while (board.pending.size() != 0) @(posedge clock);
      while (waited < LATENCY + 10) begin
         @(posedge clock);
         waited++;
      end
      $display("%0d arcs checked: endpoints, cardinal extents, wrapped and empty spans,",
               board.checked);
      $display("saturated edges, random stalls and a long response hold-off");
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("arc_bounding_box_tb OK");
      else
         $display("arc_bounding_box_tb NOT OK");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/arcbb_pkg.sv
hw/rtl/arcbb_angle_reduce.sv
hw/rtl/arcbb_cordic_cell.sv
hw/rtl/arc_bounding_box.sv
verif/arc_bounding_box_tb.sv
